[hdl/matrix_multiply_transpose_macros.svh]
// Assertion macros of the matrix multiply block, used by mmt_ctrl.
// Depends on each asserting module having ports named clock and reset.
`ifndef MATRIX_MULTIPLY_TRANSPOSE_MACROS_SVH
`define MATRIX_MULTIPLY_TRANSPOSE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MMT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising clock edge, reset included.
`define MMT_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/mmt_pkg.sv]
// Shared types and constants of the matrix multiply block.
// No dependencies; imported by every module of the block but mmt_ram.
package mmt_pkg;

   localparam int MAX_DIM_DEFAULT = 16;
   localparam int CFG_W           = 5;   // width of a dimension register
   localparam int CSR_IDX_W       = 3;
   localparam int FUNC_W          = 2;
   localparam int ADDR_IN_W       = 8;
   localparam int VAL_W           = 16;
   localparam int ROWCOL_W        = 4;
   localparam int PROD_W          = 2 * VAL_W;
   localparam int DOT_W           = 36;
   localparam int BASE_W          = ROWCOL_W + CFG_W;

   localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_OF_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_OF_B  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A_TRANS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_B_TRANS    = 3'd4;

   localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [CFG_W-1:0] rows_of_a;
      logic [CFG_W-1:0] inner_size;
      logic [CFG_W-1:0] cols_of_b;
      logic             a_trans;
      logic             b_trans;
   } cfg_type;

   typedef struct packed {
      logic wr_a;         // write the A store at the request address
      logic wr_b;         // write the B store at the request address
      logic start;        // load pointers and clear the accumulator
      logic issue;        // read one A/B pair and advance the pointers
      logic load_simple;  // load a response word with a zero dot value
      logic simple_err;   // status bit for load_simple
      logic finish;       // load the saturated sum as the response word
   } cmd_type;

   typedef struct packed {
      logic             addr_err;
      logic             rowcol_err;
      logic             rsp_busy;
      logic [CFG_W-1:0] n_eff;
   } status_type;

endpackage

[hdl/mmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mmt_ctrl.sv]
// Controller of the matrix multiply block: request handshake and sequencing.
// Depends on mmt_pkg and the assertion macros header.
`include "matrix_multiply_transpose_macros.svh"

module mmt_ctrl
   import mmt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  status_type          status,
   output cmd_type             cmd
);

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] k_ff, k_in;
   logic             accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !status.rsp_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_WRITE_A: begin
                     cmd.wr_a        = !status.addr_err;
                     cmd.load_simple = 1'b1;
                     cmd.simple_err  = status.addr_err;
                  end
                  FUNC_WRITE_B: begin
                     cmd.wr_b        = !status.addr_err;
                     cmd.load_simple = 1'b1;
                     cmd.simple_err  = status.addr_err;
                  end
                  FUNC_COMPUTE: begin
                     if (status.rowcol_err) begin
                        cmd.load_simple = 1'b1;
                        cmd.simple_err  = 1'b1;
                     end else begin
                        cmd.start = 1'b1;
                        k_in      = '0;
                        state_in  = ST_RUN;
                     end
                  end
                  default: begin
                     cmd.load_simple = 1'b1;
                     cmd.simple_err  = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (k_ff == status.n_eff) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               k_in      = k_ff + CFG_W'(1);
            end
         end
         // The last product lands in the accumulator during this cycle.
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `MMT_ASSERT(no_rsp_overwrite, (cmd.load_simple || cmd.finish) |-> !status.rsp_busy,
      "response word loaded while the previous one is still pending")
   `MMT_ASSERT(issue_bounded, cmd.issue |-> (k_ff < status.n_eff),
      "more element reads issued than the inner size")
   `MMT_ASSERT(finish_returns_idle, cmd.finish |=> (state_ff == ST_IDLE && !req_ready),
      "controller did not return to idle with a pending response")
   `MMT_ASSERT_ALWAYS(reset_to_idle, reset |=> (state_ff == ST_IDLE),
      "controller not idle after reset")

endmodule

[hdl/mmt_dp.sv]
// Datapath of the matrix multiply block: element stores, address pointers,
// multiply-accumulate lane and response register. Depends on mmt_pkg, mmt_ram.
module mmt_dp
   import mmt_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  cfg_type                     cfg,
   input  logic        [ADDR_IN_W-1:0] req_address,
   input  logic signed [VAL_W-1:0]     req_value,
   input  logic        [ROWCOL_W-1:0]  req_row,
   input  logic        [ROWCOL_W-1:0]  req_col,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic signed [DOT_W-1:0]     rsp_dot_value,
   output logic                        rsp_status
);

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ACC_W       = DOT_W + $clog2(MAX_DIM) + 1;
   localparam logic signed [ACC_W-1:0] SatHi =
      {{(ACC_W - DOT_W + 1){1'b0}}, {(DOT_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SatLo = ~SatHi;

   logic [CFG_W-1:0]  m_eff, n_eff, p_eff;
   logic [BASE_W-1:0] a_base, b_base;
   logic [ADDR_W-1:0] a_ptr_ff, a_ptr_in, b_ptr_ff, b_ptr_in;
   logic [ADDR_W-1:0] a_step, b_step, wr_addr;
   logic [VAL_W-1:0]  a_rd, b_rd;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, acc_sat;
   logic rd_v_ff, prod_v_ff;
   logic rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic signed [DOT_W-1:0] rsp_dot_ff, rsp_dot_in;

   // Dimension registers above MAX_DIM act as MAX_DIM.
   always_comb begin
      m_eff = (32'(cfg.rows_of_a)  > 32'(MAX_DIM)) ? CFG_W'(MAX_DIM) : cfg.rows_of_a;
      n_eff = (32'(cfg.inner_size) > 32'(MAX_DIM)) ? CFG_W'(MAX_DIM) : cfg.inner_size;
      p_eff = (32'(cfg.cols_of_b)  > 32'(MAX_DIM)) ? CFG_W'(MAX_DIM) : cfg.cols_of_b;
   end

   assign status.addr_err   = 32'(req_address) >= 32'(STORE_DEPTH);
   assign status.rowcol_err = ({1'b0, req_row} >= m_eff) || ({1'b0, req_col} >= p_eff);
   assign status.rsp_busy   = rsp_valid_ff;
   assign status.n_eff      = n_eff;

   assign wr_addr = ADDR_W'(req_address);

   mmt_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_a_store (
      .clock   (clock),
      .wr_en   (cmd.wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (a_ptr_ff),
      .rd_data (a_rd)
   );

   mmt_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_b_store (
      .clock   (clock),
      .wr_en   (cmd.wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (b_ptr_ff),
      .rd_data (b_rd)
   );

   // A walks along its row (stride 1) or down its stored column (stride m);
   // B walks down its column (stride p) or along its stored row (stride 1).
   always_comb begin
      a_base   = cfg.a_trans ? BASE_W'(req_row)
                             : BASE_W'(req_row) * BASE_W'(n_eff);
      b_base   = cfg.b_trans ? BASE_W'(req_col) * BASE_W'(n_eff)
                             : BASE_W'(req_col);
      a_step   = cfg.a_trans ? ADDR_W'(m_eff) : ADDR_W'(1);
      b_step   = cfg.b_trans ? ADDR_W'(1) : ADDR_W'(p_eff);
      a_ptr_in = a_ptr_ff;
      b_ptr_in = b_ptr_ff;
      if (cmd.start) begin
         a_ptr_in = ADDR_W'(a_base);
         b_ptr_in = ADDR_W'(b_base);
      end else if (cmd.issue) begin
         a_ptr_in = a_ptr_ff + a_step;
         b_ptr_in = b_ptr_ff + b_step;
      end
   end

   assign prod_in = $signed(a_rd) * $signed(b_rd);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      if (acc_ff > SatHi) begin
         acc_sat = SatHi;
      end else if (acc_ff < SatLo) begin
         acc_sat = SatLo;
      end else begin
         acc_sat = acc_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_dot_in    = rsp_dot_ff;
      if (cmd.load_simple) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.simple_err;
         rsp_dot_in    = '0;
      end else if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = 1'b0;
         rsp_dot_in    = DOT_W'(acc_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff      <= cmd.issue;
         prod_v_ff    <= rd_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ptr_ff      <= a_ptr_in;
      b_ptr_ff      <= b_ptr_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dot_ff    <= rsp_dot_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_dot_value = rsp_dot_ff;

endmodule

[hdl/matrix_multiply_transpose.sv]
// Matrix multiply with optional operand transposition. Write words (A or B
// element) and error words answer one cycle after acceptance. A compute word
// answers once its dot product is summed: one multiply-accumulate lane
// reads one A and one B element per cycle from the two element stores, and
// the store read and product registers add the pipeline tail. A new request
// word is taken once the controller is idle and the previous response word
// has been taken. Configuration words are taken every cycle.
//
// Top level; depends on mmt_pkg, mmt_ctrl, mmt_dp and mmt_ram.
module matrix_multiply_transpose
   import mmt_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [CFG_W-1:0]     csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic        [FUNC_W-1:0]    req_func,
   input  logic        [ADDR_IN_W-1:0] req_address,
   input  logic signed [VAL_W-1:0]     req_value,
   input  logic        [ROWCOL_W-1:0]  req_row,
   input  logic        [ROWCOL_W-1:0]  req_col,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DOT_W-1:0]     rsp_dot_value,
   output logic                        rsp_status
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROWS_OF_A:  cfg_in.rows_of_a  = csr_wdata;
            CSR_INNER_SIZE: cfg_in.inner_size = csr_wdata;
            CSR_COLS_OF_B:  cfg_in.cols_of_b  = csr_wdata;
            CSR_A_TRANS:    cfg_in.a_trans    = csr_wdata[0];
            CSR_B_TRANS:    cfg_in.b_trans    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows_of_a  <= DIM_RESET;
         cfg_ff.inner_size <= DIM_RESET;
         cfg_ff.cols_of_b  <= DIM_RESET;
         cfg_ff.a_trans    <= 1'b0;
         cfg_ff.b_trans    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   mmt_dp #(.MAX_DIM(MAX_DIM)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cfg           (cfg_ff),
      .req_address   (req_address),
      .req_value     (req_value),
      .req_row       (req_row),
      .req_col       (req_col),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_dot_value (rsp_dot_value),
      .rsp_status    (rsp_status)
   );

endmodule

[verif/matrix_multiply_transpose_test.sv]
// Self-checking testbench for the matrix multiply block with operand transposition.
// Loads A and B elements, requests dot products under several dimension settings and
// checks every response word against a predictor; depends on mmt_pkg and the RTL.
module matrix_multiply_transpose_test;
   import mmt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM = MAX_DIM_DEFAULT;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam longint DOT_TOP = (longint'(1) <<< (DOT_W - 1)) - 1;
   localparam longint DOT_BOTTOM = -DOT_TOP - 1;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // Holds the dimension registers and both element stores as the block should see
   // them, and the queue of response words still owed.
   class gemm_board;
      logic [CFG_W-1:0] m_rows, k_inner, n_cols;
      logic a_transposed, b_transposed;
      logic [VAL_W-1:0] a_elems [STORE_DEPTH];
      logic [VAL_W-1:0] b_elems [STORE_DEPTH];
      logic signed [DOT_W-1:0] expected_dot [$];
      logic expected_status [$];
      int mismatches;

      function new();
         m_rows = DIM_RESET;
         k_inner = DIM_RESET;
         n_cols = DIM_RESET;
         a_transposed = 1'b0;
         b_transposed = 1'b0;
         mismatches = 0;
         foreach (a_elems[i]) begin
            a_elems[i] = '0;
            b_elems[i] = '0;
         end
      endfunction

      function int unsigned clip_dim(logic [CFG_W-1:0] d);
         return (d > MAX_DIM) ? MAX_DIM : d;
      endfunction

      function int unsigned a_slot(int unsigned r, int unsigned k);
         int unsigned m, n;
         m = clip_dim(m_rows);
         n = clip_dim(k_inner);
         return (a_transposed ? k * m + r : r * n + k) % STORE_DEPTH;
      endfunction

      function int unsigned b_slot(int unsigned k, int unsigned c);
         int unsigned n, p;
         n = clip_dim(k_inner);
         p = clip_dim(n_cols);
         return (b_transposed ? c * n + k : k * p + c) % STORE_DEPTH;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_ROWS_OF_A: m_rows = data;
            CSR_INNER_SIZE: k_inner = data;
            CSR_COLS_OF_B: n_cols = data;
            CSR_A_TRANS: a_transposed = data[0];
            CSR_B_TRANS: b_transposed = data[0];
            default: ;
         endcase
      endfunction

      function void accept_word(logic [FUNC_W-1:0] f, logic [ADDR_IN_W-1:0] addr,
                                logic [VAL_W-1:0] v, logic [ROWCOL_W-1:0] r,
                                logic [ROWCOL_W-1:0] c);
         int unsigned k;
         longint acc;
         logic signed [DOT_W-1:0] dot;
         logic st;
         dot = '0;
         st = 1'b0;
         case (f)
            FUNC_WRITE_A: begin
               if (addr < STORE_DEPTH) a_elems[addr] = v;
               else st = 1'b1;
            end
            FUNC_WRITE_B: begin
               if (addr < STORE_DEPTH) b_elems[addr] = v;
               else st = 1'b1;
            end
            FUNC_COMPUTE: begin
               if (r >= clip_dim(m_rows) || c >= clip_dim(n_cols)) begin
                  st = 1'b1;
               end else begin
                  acc = 0;
                  for (k = 0; k < clip_dim(k_inner); k++)
                     acc += longint'($signed(a_elems[a_slot(r, k)]))
                          * longint'($signed(b_elems[b_slot(k, c)]));
                  if (acc > DOT_TOP) acc = DOT_TOP;
                  if (acc < DOT_BOTTOM) acc = DOT_BOTTOM;
                  dot = acc[DOT_W-1:0];
               end
            end
            default: st = 1'b1;
         endcase
         expected_dot.insert(expected_dot.size(), dot);
         expected_status.insert(expected_status.size(), st);
      endfunction

      function void check_word(logic signed [DOT_W-1:0] dot, logic st);
         logic signed [DOT_W-1:0] want_dot;
         logic want_st;
         if (expected_dot.size() == 0) begin
            $display("%0t: response word with nothing owed, dot_value %0d status %0d",
                     $time, dot, st);
            mismatches++;
            return;
         end
         want_dot = expected_dot.pop_front();
         want_st = expected_status.pop_front();
         if (dot !== want_dot) begin
            $display("%0t: dot_value expected %0d actual %0d", $time, want_dot, dot);
            mismatches++;
         end
         if (st !== want_st) begin
            $display("%0t: status expected %0d actual %0d", $time, want_st, st);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_dot.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [FUNC_W-1:0] req_func = '0;
   logic [ADDR_IN_W-1:0] req_address = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic [ROWCOL_W-1:0] req_row = '0;
   logic [ROWCOL_W-1:0] req_col = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DOT_W-1:0] rsp_dot_value;
   logic rsp_status;

   gemm_board board;
   bit a_loaded [STORE_DEPTH];
   bit b_loaded [STORE_DEPTH];
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   bit long_stall_armed = 1'b0;
   int extreme_percent = 20;

   matrix_multiply_transpose #(.MAX_DIM(MAX_DIM)) uut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_address(req_address),
      .req_value(req_value),
      .req_row(req_row),
      .req_col(req_col),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_dot_value(rsp_dot_value),
      .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_word(rsp_dot_value, rsp_status);
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (long_stall_armed) begin
            long_stall_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (receiver_idles) begin
            rsp_ready <= ($urandom_range(99) >= 13);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [VAL_W-1:0] pick_element();
      if ($urandom_range(99) < extreme_percent)
         return ($urandom_range(3) == 0) ? 16'h7fff : 16'h8000;
      return VAL_W'($urandom);
   endfunction

   task automatic send_word(input logic [FUNC_W-1:0] f, input logic [ADDR_IN_W-1:0] a,
                            input logic [VAL_W-1:0] v, input logic [ROWCOL_W-1:0] r,
                            input logic [ROWCOL_W-1:0] c);
      if (sender_idles && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 40) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_address <= a;
      req_value <= v;
      req_row <= r;
      req_col <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.accept_word(f, a, v, r, c);
      if (f == FUNC_WRITE_A) a_loaded[a] = 1'b1;
      else if (f == FUNC_WRITE_B) b_loaded[a] = 1'b1;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(idx, data);
   endtask

   // The upper bits of the transpose words and the write to a spare index must be
   // ignored by the block.
   task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                           input logic [CFG_W-1:0] cols, input logic ta, input logic tb);
      write_csr(CSR_ROWS_OF_A, rows);
      write_csr(CSR_INNER_SIZE, inner);
      write_csr(CSR_COLS_OF_B, cols);
      write_csr(CSR_A_TRANS, {4'($urandom), ta});
      write_csr(CSR_B_TRANS, {4'($urandom), tb});
      write_csr(CSR_B_TRANS + 3'($urandom_range(3, 1)), CFG_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Elements that a dot product would read are loaded first, so that no store
   // entry is ever read before it was written.
   task automatic compute_at(input logic [ROWCOL_W-1:0] r, input logic [ROWCOL_W-1:0] c);
      int unsigned k, ai, bi;
      if (r < board.clip_dim(board.m_rows) && c < board.clip_dim(board.n_cols)) begin
         for (k = 0; k < board.clip_dim(board.k_inner); k++) begin
            ai = board.a_slot(r, k);
            bi = board.b_slot(k, c);
            if (!a_loaded[ai])
               send_word(FUNC_WRITE_A, ADDR_IN_W'(ai), pick_element(),
                         ROWCOL_W'($urandom), ROWCOL_W'($urandom));
            if (!b_loaded[bi])
               send_word(FUNC_WRITE_B, ADDR_IN_W'(bi), pick_element(),
                         ROWCOL_W'($urandom), ROWCOL_W'($urandom));
         end
      end
      send_word(FUNC_COMPUTE, ADDR_IN_W'($urandom), VAL_W'($urandom), r, c);
   endtask

   task automatic random_item();
      int unsigned pick, m, p;
      logic [ROWCOL_W-1:0] r, c;
      pick = $urandom_range(99);
      m = board.clip_dim(board.m_rows);
      p = board.clip_dim(board.n_cols);
      if (pick < 45) begin
         if (m == 0 || p == 0 || $urandom_range(99) < 15) begin
            r = ROWCOL_W'($urandom);
            c = ROWCOL_W'($urandom);
         end else begin
            r = ROWCOL_W'($urandom_range(m - 1));
            c = ROWCOL_W'($urandom_range(p - 1));
         end
         compute_at(r, c);
      end else if (pick < 70) begin
         send_word(FUNC_WRITE_A, ADDR_IN_W'($urandom), pick_element(),
                   ROWCOL_W'($urandom), ROWCOL_W'($urandom));
      end else if (pick < 95) begin
         send_word(FUNC_WRITE_B, ADDR_IN_W'($urandom), pick_element(),
                   ROWCOL_W'($urandom), ROWCOL_W'($urandom));
      end else begin
         send_word(FUNC_UNUSED, ADDR_IN_W'($urandom), VAL_W'($urandom),
                   ROWCOL_W'($urandom), ROWCOL_W'($urandom));
      end
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                            input logic [CFG_W-1:0] cols, input logic ta, input logic tb,
                            input int count);
      settle();
      set_dims(rows, inner, cols, ta, tb);
      repeat (count) random_item();
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Two by two, both operands stored transposed, full-scale element values.
      set_dims(5'd2, 5'd2, 5'd2, 1'b1, 1'b1);
      send_word(FUNC_WRITE_A, 8'd0, 16'h8000, 4'd0, 4'd15);
      send_word(FUNC_WRITE_A, 8'd1, 16'h7fff, 4'd15, 4'd0);
      send_word(FUNC_WRITE_A, 8'd2, 16'h0001, 4'd0, 4'd0);
      send_word(FUNC_WRITE_A, 8'd3, 16'hffff, 4'd15, 4'd15);
      send_word(FUNC_WRITE_B, 8'd0, 16'h8000, 4'd0, 4'd0);
      send_word(FUNC_WRITE_B, 8'd1, 16'h8000, 4'd0, 4'd0);
      send_word(FUNC_WRITE_B, 8'd2, 16'h7fff, 4'd0, 4'd0);
      send_word(FUNC_WRITE_B, 8'd3, 16'hffff, 4'd0, 4'd0);
      send_word(FUNC_WRITE_A, 8'd255, 16'h5555, 4'd15, 4'd15);
      send_word(FUNC_WRITE_B, 8'd255, 16'haaaa, 4'd0, 4'd0);
      compute_at(4'd0, 4'd0);
      compute_at(4'd1, 4'd1);
      compute_at(4'd0, 4'd1);
      compute_at(4'd1, 4'd0);
      compute_at(4'd2, 4'd0);
      compute_at(4'd0, 4'd2);
      compute_at(4'd15, 4'd15);
      send_word(FUNC_UNUSED, 8'd255, 16'h7fff, 4'd15, 4'd15);
      send_word(FUNC_UNUSED, 8'd0, 16'h0000, 4'd0, 4'd0);

      extreme_percent = 90;
      run_phase(5'd16, 5'd16, 5'd16, 1'b0, 1'b0, 150);
      extreme_percent = 20;
      // The response side holds off while this phase keeps offering words.
      settle();
      set_dims(5'd31, 5'd31, 5'd31, 1'b1, 1'b0);
      long_stall_armed = 1'b1;
      repeat (120) random_item();
      run_phase(5'd0, 5'd5, 5'd3, 1'b0, 1'b1, 80);
      run_phase(5'd4, 5'd0, 5'd4, 1'b1, 1'b1, 80);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      run_phase(5'd1, 5'd16, 5'd1, 1'b0, 1'b0, 120);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      run_phase(5'd16, 5'd1, 5'd16, 1'b1, 1'b1, 120);
      run_phase(5'd17, 5'd20, 5'd16, 1'b0, 1'b1, 120);
      run_phase(5'd3, 5'd7, 5'd5, 1'b1, 1'b0, 120);
      repeat (2)
         run_phase(CFG_W'($urandom_range(17, 1)), CFG_W'($urandom_range(17, 1)),
                   CFG_W'($urandom_range(17, 1)), 1'($urandom), 1'($urandom), 80);

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.pending() != 0)
         $display("%0t: %0d response words never arrived", $time, board.pending());
      if (board.mismatches == 0 && board.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
